// ===== rtl/waveform_pedestal_mean_rms_macros.svh =====
// Assertion macros shared by the pedestal mean / rms RTL.
`ifndef WAVEFORM_PEDESTAL_MEAN_RMS_MACROS_SVH
`define WAVEFORM_PEDESTAL_MEAN_RMS_MACROS_SVH
`ifndef SYNTH
// Condition holds at every clock edge out of reset
`define WPMR_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("wpmr assertion failed");
// Antecedent implies consequent in the same cycle
`define WPMR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wpmr assertion failed");
// Antecedent implies consequent in the next cycle
`define WPMR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wpmr assertion failed");
`else
`define WPMR_ASSERT(lbl, cond)
`define WPMR_ASSERT_IMP(lbl, ante, cons)
`define WPMR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/wpmr_pkg.sv =====
// Package: widths, window record and divider interface types for the pedestal block.
`default_nettype none
package wpmr_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int WIN_W      = 7;
    localparam int SAMPLE_W   = 16;
    localparam int SQR_W      = 2 * SAMPLE_W;
    localparam int SUM_W      = 22;
    localparam int SQ_W       = 37;
    localparam int OUT_W      = 20;
    localparam int NUM_W      = 43;
    localparam int DEN_W      = 12;
    localparam int DIVD_W     = NUM_W + 8;
    localparam int ROOT_W     = 25;
    localparam int QV_W       = 2 * ROOT_W;
    localparam int SREM_W     = ROOT_W + 1;
    localparam int DSTEP_W    = $clog2(DIVD_W + 1);
    localparam int RSTEP_W    = $clog2(ROOT_W + 1);

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);
    localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(2);
    localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);

    // One closed window handed from front to back
    typedef struct packed {
        logic [WIN_W-1:0]        n;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sumsq;
    } wpmr_win_t;

    // Divider request and status
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DEN_W-1:0]  divisor;
    } wpmr_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } wpmr_div_sts_t;

endpackage
`default_nettype wire

// ===== rtl/wpmr_front.sv =====
// Front end: window size register, sample accumulation and window close detection.
`default_nettype none
module wpmr_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [wpmr_pkg::WIN_W-1:0]      cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [wpmr_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                            s_waveform_start,
    output logic                            push,
    output wpmr_pkg::wpmr_win_t             win,
    input  logic                            q_full
);
    import wpmr_pkg::*;

    logic [WIN_W-1:0]        win_size_reg, win_size_next;
    logic [WIN_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic                    done_reg, done_next;

    logic                    beat;
    logic                    active;
    logic                    close;
    logic [WIN_W-1:0]        eff_n;
    logic [WIN_W-1:0]        base_cnt, cnt_new;
    logic signed [SUM_W-1:0] base_sum, sum_new;
    logic [SQ_W-1:0]         base_sq, sq_new;
    logic signed [SQR_W-1:0] sample_sqr;

    // Stall only on a full queue
    assign s_ready = !q_full;
    assign beat    = s_valid && s_ready;

    // Effective window length, clamped
    always_comb begin
        if (win_size_reg < WIN_MIN) begin
            eff_n = WIN_MIN;
        end else if (win_size_reg > WIN_MAX) begin
            eff_n = WIN_MAX;
        end else begin
            eff_n = win_size_reg;
        end
    end

    // Accumulate; a start flag restarts from zero
    always_comb begin
        active     = s_waveform_start || !done_reg;
        base_cnt   = s_waveform_start ? '0 : cnt_reg;
        base_sum   = s_waveform_start ? '0 : sum_reg;
        base_sq    = s_waveform_start ? '0 : sq_reg;
        sample_sqr = SQR_W'(s_sample) * SQR_W'(s_sample);
        cnt_new    = WIN_W'(base_cnt + WIN_W'(1));
        sum_new    = base_sum + SUM_W'(s_sample);
        sq_new     = base_sq + {{(SQ_W-SQR_W){1'b0}}, sample_sqr};
        close      = active && (cnt_new >= eff_n);
    end

    assign push      = beat && close;
    assign win.n     = cnt_new;
    assign win.sum   = sum_new;
    assign win.sumsq = sq_new;

    // Next state
    always_comb begin
        win_size_next = cfg_wr_en ? cfg_wr_data : win_size_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        sq_next       = sq_reg;
        done_next     = done_reg;
        if (beat && active) begin
            if (close) begin
                cnt_next  = '0;
                sum_next  = '0;
                sq_next   = '0;
                done_next = 1'b1;
            end else begin
                cnt_next  = cnt_new;
                sum_next  = sum_new;
                sq_next   = sq_new;
                done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg <= WIN_RESET;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            sq_reg       <= '0;
            done_reg     <= 1'b1;
        end else begin
            win_size_reg <= win_size_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            sq_reg       <= sq_next;
            done_reg     <= done_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wpmr_queue.sv =====
// Two-entry queue of closed windows between front and back.
`default_nettype none
`include "waveform_pedestal_mean_rms_macros.svh"
module wpmr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  wpmr_pkg::wpmr_win_t wr_data,
    output logic                full,
    input  logic                pop,
    output wpmr_pkg::wpmr_win_t rd_data,
    output logic                empty
);
    import wpmr_pkg::*;

    wpmr_win_t  ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = ent_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = 2'(cnt_reg + 2'd1);
        end else if (pop && !push) begin
            cnt_next = 2'(cnt_reg - 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `WPMR_ASSERT_IMP(a_no_push_full, push, !full)
    `WPMR_ASSERT_IMP(a_no_pop_empty, pop, !empty)
    `WPMR_ASSERT_NEXT(a_fill_up, aresetn && push && !pop, cnt_reg == 2'($past(cnt_reg) + 2'd1))

endmodule
`default_nettype wire

// ===== rtl/wpmr_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module wpmr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wpmr_pkg::wpmr_div_req_t       req,
    output wpmr_pkg::wpmr_div_sts_t       sts,
    output logic [wpmr_pkg::DIVD_W-1:0]   quot,
    output logic [wpmr_pkg::DEN_W-1:0]    rem
);
    import wpmr_pkg::*;

    logic [DIVD_W-1:0]  q_reg, q_next;
    logic [DEN_W-1:0]   r_reg, r_next;
    logic [DEN_W-1:0]   d_reg, d_next;
    logic [DSTEP_W-1:0] step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [DEN_W:0]     shifted;
    logic [DEN_W:0]     diff;
    logic               ge;

    // Trial subtraction of the divisor from the shifted remainder
    always_comb begin
        shifted = {r_reg, q_reg[DIVD_W-1]};
        diff    = shifted - {1'b0, d_reg};
        ge      = (shifted >= {1'b0, d_reg});
    end

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
            step_next = DSTEP_W'(DIVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next    = {q_reg[DIVD_W-2:0], ge};
            r_next    = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            step_next = DSTEP_W'(step_reg - DSTEP_W'(1));
            if (step_reg == DSTEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = q_reg;
    assign rem      = r_reg;

endmodule
`default_nettype wire

// ===== rtl/wpmr_back.sv =====
// Back end: products, mean and variance divides, serial square root, result register.
`default_nettype none
`include "waveform_pedestal_mean_rms_macros.svh"
module wpmr_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  wpmr_pkg::wpmr_win_t            q_data,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [wpmr_pkg::OUT_W-1:0] m_pedestal_q4,
    output logic [wpmr_pkg::OUT_W-1:0]     m_rms_q4
);
    import wpmr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_WMEAN,
        ST_DVAR,
        ST_WVAR,
        ST_ROOT,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [WIN_W-1:0]        n_reg, n_next;
    logic                    neg_reg, neg_next;
    logic [SUM_W-1:0]        mag_reg, mag_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [NUM_W-1:0]        ns2_reg, ns2_next;
    logic [NUM_W-1:0]        ss_reg, ss_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic signed [OUT_W-1:0] mean_reg, mean_next;
    logic [QV_W-1:0]         qv_reg, qv_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [SREM_W-1:0]       srem_reg, srem_next;
    logic [RSTEP_W-1:0]      rstep_reg, rstep_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0] m_ped_reg, m_ped_next;
    logic [OUT_W-1:0]        m_rms_reg, m_rms_next;

    logic [WIN_W+SQ_W-1:0]   prod_ns2;
    logic [2*SUM_W-1:0]      prod_ss;
    logic [2*WIN_W-1:0]      prod_den;
    logic [OUT_W:0]          qmag;
    logic [OUT_W:0]          qsigned;
    logic [SREM_W+1:0]       srem_sh;
    logic [SREM_W+1:0]       trial;

    wpmr_div_req_t           div_req;
    wpmr_div_sts_t           div_sts;
    logic [DIVD_W-1:0]       div_quot;
    logic [DEN_W-1:0]        div_rem;

    wpmr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .sts     (div_sts),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    // Products, one registered stage
    assign prod_ns2 = n_reg * sq_reg;
    assign prod_ss  = mag_reg * mag_reg;
    assign prod_den = n_reg * (n_reg - WIN_W'(1));

    // Floor of the mean: round magnitude up on a negative sum with remainder
    always_comb begin
        qmag    = (OUT_W+1)'(div_quot[OUT_W:0] + (OUT_W+1)'(neg_reg && (div_rem != '0)));
        qsigned = neg_reg ? (OUT_W+1)'(-qmag) : qmag;
    end

    // One root digit per cycle
    always_comb begin
        srem_sh = {srem_reg, qv_reg[QV_W-1:QV_W-2]};
        trial   = {1'b0, root_reg, 2'b01};
    end

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        sq_next      = sq_reg;
        ns2_next     = ns2_reg;
        ss_next      = ss_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        mean_next    = mean_reg;
        qv_next      = qv_reg;
        root_next    = root_reg;
        srem_next    = srem_reg;
        rstep_next   = rstep_reg;
        m_ped_next   = m_ped_reg;
        m_rms_next   = m_rms_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        div_req      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    n_next     = q_data.n;
                    neg_next   = q_data.sum < 0;
                    mag_next   = q_data.sum < 0 ? SUM_W'(-q_data.sum) : SUM_W'(q_data.sum);
                    sq_next    = q_data.sumsq;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                ns2_next   = prod_ns2[NUM_W-1:0];
                ss_next    = prod_ss[NUM_W-1:0];
                den_next   = prod_den[DEN_W-1:0];
                state_next = ST_SUB;
            end
            ST_SUB: begin
                num_next         = ns2_reg - ss_reg;
                div_req.start    = 1'b1;
                div_req.dividend = DIVD_W'({mag_reg, 4'b0000});
                div_req.divisor  = DEN_W'(n_reg);
                state_next       = ST_WMEAN;
            end
            ST_WMEAN: begin
                if (div_sts.done) begin
                    mean_next  = qsigned[OUT_W-1:0];
                    state_next = ST_DVAR;
                end
            end
            ST_DVAR: begin
                div_req.start    = 1'b1;
                div_req.dividend = {num_reg, 8'h00};
                div_req.divisor  = den_reg;
                state_next       = ST_WVAR;
            end
            ST_WVAR: begin
                if (div_sts.done) begin
                    qv_next    = div_quot[QV_W-1:0];
                    root_next  = '0;
                    srem_next  = '0;
                    rstep_next = RSTEP_W'(ROOT_W);
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (srem_sh >= trial) begin
                    srem_next = SREM_W'(srem_sh - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    srem_next = srem_sh[SREM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                qv_next    = {qv_reg[QV_W-3:0], 2'b00};
                rstep_next = RSTEP_W'(rstep_reg - RSTEP_W'(1));
                if (rstep_reg == RSTEP_W'(1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ped_next   = mean_reg;
                    m_rms_next   = root_reg[OUT_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg     <= n_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        sq_reg    <= sq_next;
        ns2_reg   <= ns2_next;
        ss_reg    <= ss_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        mean_reg  <= mean_next;
        qv_reg    <= qv_next;
        root_reg  <= root_next;
        srem_reg  <= srem_next;
        rstep_reg <= rstep_next;
        m_ped_reg <= m_ped_next;
        m_rms_reg <= m_rms_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pedestal_q4 = m_ped_reg;
    assign m_rms_q4      = m_rms_reg;

    `WPMR_ASSERT_IMP(a_div_start_idle, div_req.start, !div_sts.busy)
    `WPMR_ASSERT_IMP(a_wait_has_div, state_reg == ST_WMEAN || state_reg == ST_WVAR, div_sts.busy || div_sts.done)
    `WPMR_ASSERT_IMP(a_pop_in_idle, q_pop, state_reg == ST_IDLE && !q_empty)

endmodule
`default_nettype wire

// ===== rtl/waveform_pedestal_mean_rms.sv =====
// Top level: pedestal mean and sample standard deviation over a waveform's leading samples.
//
// Input beats (s_valid/s_ready) carry one signed 16-bit sample and a start flag.
// A start flag opens a window; the first window_size samples (clamped to 2..64)
// are summed together with their squares, later samples of the waveform are dropped.
// When the window fills, one result beat (m_valid/m_ready) carries the floored
// Q4 mean and the floored Q4 sample standard deviation.
// The front end takes one sample per cycle. A closed window goes into a two-entry
// queue; the back end works on one window at a time, through two 51-step serial
// divides and a 25-step serial root. The front end stalls only while the queue
// is full.
// A stalled receiver holds the result register; the back end finishes the next window
// and waits, the queue then fills and s_ready drops.
// cfg_wr_en/cfg_wr_data write window_size; write only while idle.
// Synchronous active-low reset: window_size returns to 8, no window is open and
// no result is pending.
`default_nettype none
module waveform_pedestal_mean_rms (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [wpmr_pkg::WIN_W-1:0]           cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [wpmr_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 s_waveform_start,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [wpmr_pkg::OUT_W-1:0]    m_pedestal_q4,
    output logic [wpmr_pkg::OUT_W-1:0]           m_rms_q4
);
    import wpmr_pkg::*;

    wpmr_win_t push_win;
    wpmr_win_t pop_win;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;

    wpmr_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_waveform_start (s_waveform_start),
        .push             (push),
        .win              (push_win),
        .q_full           (q_full)
    );

    wpmr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (push_win),
        .full    (q_full),
        .pop     (pop),
        .rd_data (pop_win),
        .empty   (q_empty)
    );

    wpmr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_data        (pop_win),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pedestal_q4 (m_pedestal_q4),
        .m_rms_q4      (m_rms_q4)
    );

endmodule
`default_nettype wire
